FILE: hw/rtl/mexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, state encoding and controller/datapath word types for the
// modular exponentiation core.
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int VAL_W      = 31;             // base, modulus, power
	localparam int EXP_BITS   = 32;             // exponent bits scanned
	localparam int PROD_W     = 2 * VAL_W;      // full product width
	localparam int STEP_CNT_W = $clog2(VAL_W);
	localparam int BIT_CNT_W  = $clog2(EXP_BITS);

	localparam logic [STEP_CNT_W-1:0] RED_LAST  = STEP_CNT_W'(VAL_W - 1);
	localparam logic [BIT_CNT_W-1:0]  BIT_LAST  = BIT_CNT_W'(EXP_BITS - 1);
	localparam logic [VAL_W-1:0]      MOD_RESET = VAL_W'(2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE_RED,
		ST_BIT,
		ST_MUL_ACC,
		ST_RED_ACC,
		ST_MUL_SQ,
		ST_RED_SQ,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // capture base/exponent, acc = 1
		logic mul_go;      // product into remainder/low shift registers
		logic mul_sel_acc; // multiply acc * sq instead of sq * sq
		logic red_step;    // one restoring remainder step
		logic wr_acc;      // final step result into acc
		logic wr_sq;       // final step result into sq
		logic exp_shift;   // drop exponent LSB
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic exp_bit0;
	} sts_t;

endpackage

FILE: hw/rtl/mexp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for square-and-multiply: base reduction, then per exponent bit an
// optional multiply-reduce into acc and a square-reduce into sq.
// ----------------------------------------------------------------------------
module mexp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mexp_pkg::sts_t    sts,
	output mexp_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              done
);

	mexp_pkg::state_t state_q, state_d;

	logic [mexp_pkg::STEP_CNT_W-1:0] step_cnt_q;
	logic [mexp_pkg::BIT_CNT_W-1:0]  bit_cnt_q;
	logic                            red_active;
	logic                            red_last;
	logic                            bit_last;

	assign red_active = (state_q == mexp_pkg::ST_BASE_RED) ||
	                    (state_q == mexp_pkg::ST_RED_ACC)  ||
	                    (state_q == mexp_pkg::ST_RED_SQ);
	assign red_last   = (step_cnt_q == mexp_pkg::RED_LAST);
	assign bit_last   = (bit_cnt_q == mexp_pkg::BIT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mexp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_cnt_q <= '0;
			bit_cnt_q  <= '0;
		end else begin
			if (red_active && !red_last) begin
				step_cnt_q <= step_cnt_q + 1'b1;
			end else begin
				step_cnt_q <= '0;
			end
			if (cmd.load) begin
				bit_cnt_q <= '0;
			end else if (cmd.exp_shift) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			mexp_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = mexp_pkg::ST_BASE_RED;
				end
			end
			mexp_pkg::ST_BASE_RED: begin
				cmd.red_step = 1'b1;
				if (red_last) begin
					cmd.wr_sq = 1'b1;
					state_d   = mexp_pkg::ST_BIT;
				end
			end
			mexp_pkg::ST_BIT: begin
				state_d = sts.exp_bit0 ? mexp_pkg::ST_MUL_ACC : mexp_pkg::ST_MUL_SQ;
			end
			mexp_pkg::ST_MUL_ACC: begin
				cmd.mul_go      = 1'b1;
				cmd.mul_sel_acc = 1'b1;
				state_d         = mexp_pkg::ST_RED_ACC;
			end
			mexp_pkg::ST_RED_ACC: begin
				cmd.red_step = 1'b1;
				if (red_last) begin
					cmd.wr_acc = 1'b1;
					state_d    = mexp_pkg::ST_MUL_SQ;
				end
			end
			mexp_pkg::ST_MUL_SQ: begin
				cmd.mul_go = 1'b1;
				state_d    = mexp_pkg::ST_RED_SQ;
			end
			mexp_pkg::ST_RED_SQ: begin
				cmd.red_step = 1'b1;
				if (red_last) begin
					cmd.wr_sq     = 1'b1;
					cmd.exp_shift = 1'b1;
					state_d       = bit_last ? mexp_pkg::ST_DONE : mexp_pkg::ST_BIT;
				end
			end
			mexp_pkg::ST_DONE: begin
				done    = 1'b1;
				state_d = mexp_pkg::ST_IDLE;
			end
			default: begin
				state_d = mexp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/mexp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_dp
// Operand registers, one 31x31 multiplier and a bit-serial restoring
// remainder unit (one quotient bit per cycle while red_step is high).
// ----------------------------------------------------------------------------
module mexp_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mexp_pkg::cmd_t              cmd,
	output mexp_pkg::sts_t              sts,
	input  logic [mexp_pkg::VAL_W-1:0]  base,
	input  logic [mexp_pkg::EXP_BITS-1:0] exponent,
	input  logic                        cfg_we,
	input  logic [mexp_pkg::VAL_W-1:0]  cfg_data,
	output logic [mexp_pkg::VAL_W-1:0]  power
);

	logic [mexp_pkg::VAL_W-1:0]    modulus_q;
	logic [mexp_pkg::VAL_W-1:0]    acc_q;
	logic [mexp_pkg::VAL_W-1:0]    sq_q;
	logic [mexp_pkg::EXP_BITS-1:0] exp_q;
	logic [mexp_pkg::VAL_W-1:0]    rem_q;   // partial remainder, < a nonzero modulus
	logic [mexp_pkg::VAL_W-1:0]    low_q;   // dividend bits still to shift in

	logic [mexp_pkg::VAL_W-1:0]    mul_a;
	logic [mexp_pkg::PROD_W-1:0]   prod;
	logic [mexp_pkg::VAL_W:0]      shifted;
	logic [mexp_pkg::VAL_W:0]      mod_ext;
	logic [mexp_pkg::VAL_W:0]      diff;
	logic                          ge;
	logic [mexp_pkg::VAL_W-1:0]    rem_next;
	logic [mexp_pkg::VAL_W-1:0]    red_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= mexp_pkg::MOD_RESET;
		end else if (cfg_we) begin
			modulus_q <= cfg_data;
		end
	end

	// operands stay below the modulus after base reduction, so the high half
	// of any product is already a valid partial remainder
	assign mul_a = cmd.mul_sel_acc ? acc_q : sq_q;
	assign prod  = mexp_pkg::PROD_W'(mul_a) * mexp_pkg::PROD_W'(sq_q);

	assign shifted  = {rem_q, low_q[mexp_pkg::VAL_W-1]};
	assign mod_ext  = {1'b0, modulus_q};
	assign ge       = (shifted >= mod_ext);
	assign diff     = shifted - mod_ext;
	assign rem_next = ge ? diff[mexp_pkg::VAL_W-1:0] : shifted[mexp_pkg::VAL_W-1:0];
	// zero modulus reduces everything to zero
	assign red_val  = (modulus_q == '0) ? '0 : rem_next;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= '0;
			low_q <= base;
			acc_q <= mexp_pkg::VAL_W'(1);
			exp_q <= exponent;
		end else begin
			if (cmd.mul_go) begin
				rem_q <= prod[mexp_pkg::PROD_W-1:mexp_pkg::VAL_W];
				low_q <= prod[mexp_pkg::VAL_W-1:0];
			end else if (cmd.red_step) begin
				rem_q <= rem_next;
				low_q <= {low_q[mexp_pkg::VAL_W-2:0], 1'b0};
			end
			if (cmd.wr_acc) begin
				acc_q <= red_val;
			end
			if (cmd.exp_shift) begin
				exp_q <= {1'b0, exp_q[mexp_pkg::EXP_BITS-1:1]};
			end
		end
		if (cmd.wr_sq) begin
			sq_q <= red_val;
		end
	end

	assign sts.exp_bit0 = exp_q[0];
	assign power        = acc_q;

endmodule

FILE: hw/rtl/modular_exponentiation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// power = base ^ exponent mod modulus, right-to-left square-and-multiply over
// all 32 exponent bits; a zero exponent returns 1 unreduced.
// ----------------------------------------------------------------------------
//
// channel   signals                       word
// -------   ---------------------------   ---------------------------------
// input     start / busy                  base[30:0], exponent[31:0]
// result    done (one-cycle strobe)       power[30:0]
// config    cfg_valid / cfg_ready         cfg_data[30:0] -> modulus
//
// Per word: accept, base reduction (31 remainder steps), then per exponent
//   bit a decision state, a multiply into acc when the bit is set and a
//   square, each a multiply plus 31 remainder steps; after the last bit, done.
// Reset: arst_n clears the sequencer and sets modulus to 2.
// busy stays high from the accepting edge through the done cycle; done holds
//   power for exactly one cycle and the receiver cannot stall it.
// cfg_ready follows !busy; modulus changes only between words.
//
module modular_exponentiation_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// command channel
	input  logic                          start,
	output logic                          busy,
	input  logic [mexp_pkg::VAL_W-1:0]    base,
	input  logic [mexp_pkg::EXP_BITS-1:0] exponent,
	// result strobe
	output logic                          done,
	output logic [mexp_pkg::VAL_W-1:0]    power,
	// modulus write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mexp_pkg::VAL_W-1:0]    cfg_data
);

	mexp_pkg::cmd_t cmd;
	mexp_pkg::sts_t sts;
	logic           cfg_we;

	assign cfg_ready = !busy;
	assign cfg_we    = cfg_valid && cfg_ready;

	// sequencer: counts remainder steps and exponent bits
	mexp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// operand registers, multiplier, serial remainder, modulus register
	mexp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.base     (base),
		.exponent (exponent),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.power    (power)
	);

endmodule

FILE: hw/rtl/mexp_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_chk
// Port-level checks on the command/done sequencing of the core.
// ----------------------------------------------------------------------------
module mexp_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_ready
);

	// an accepted word makes the core report busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("core not busy after accepting a word");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done while not busy");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("core did not return to idle after done");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !busy)
		else $error("modulus writable while a word is in flight");

endmodule

bind modular_exponentiation_core mexp_chk u_mexp_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_ready (cfg_ready)
);
